>>> rtl/core/csc_pkg.sv
`timescale 1ns / 1ps
// Color space converter package: fixed-point coefficients, space codes,
// pixel type and the saturating shift helper. No dependencies.
package csc_pkg;

    localparam int FRAC_BITS = 16;

    localparam int DCW    = FRAC_BITS + 1;       // decode coefficient width
    localparam int ECW    = FRAC_BITS;           // encode coefficient width
    localparam int PDW    = FRAC_BITS + 12;      // decode chroma product width
    localparam int DBW    = FRAC_BITS + 11;      // encode difference width
    localparam int EPW    = 2 * FRAC_BITS + 12;  // encode chroma product width
    localparam int PW     = 2 * FRAC_BITS + 13;  // encode chroma sum width
    localparam int SATW   = 2 * FRAC_BITS + 16;
    localparam int DIV_NW = 24;
    localparam int DIV_DW = 16;
    localparam int DIV_STG = 4;
    localparam int DEC_STG = 7;
    localparam int ENC_STG = 7;
    localparam int NSTG    = DEC_STG + ENC_STG;

    localparam logic [2:0] SP_RGB   = 3'd0;
    localparam logic [2:0] SP_HSL   = 3'd1;
    localparam logic [2:0] SP_HSV   = 3'd2;
    localparam logic [2:0] SP_Y601  = 3'd3;
    localparam logic [2:0] SP_Y709  = 3'd4;
    localparam logic [2:0] SP_YCOCG = 3'd5;
    localparam logic [2:0] SP_CMY   = 3'd6;

    localparam logic CFG_SRC = 1'b0;
    localparam logic CFG_TGT = 1'b1;

    localparam logic [DCW-1:0] D_RCR_601 =
        DCW'(((64'd1402 << FRAC_BITS) + 64'd500) / 64'd1000);
    localparam logic [DCW-1:0] D_GCB_601 =
        DCW'(((64'd202008 << FRAC_BITS) + 64'd293500) / 64'd587000);
    localparam logic [DCW-1:0] D_GCR_601 =
        DCW'(((64'd419198 << FRAC_BITS) + 64'd293500) / 64'd587000);
    localparam logic [DCW-1:0] D_BCB_601 =
        DCW'(((64'd1772 << FRAC_BITS) + 64'd500) / 64'd1000);
    localparam logic [DCW-1:0] D_RCR_709 =
        DCW'(((64'd15748 << FRAC_BITS) + 64'd5000) / 64'd10000);
    localparam logic [DCW-1:0] D_GCB_709 =
        DCW'(((64'd13397432 << FRAC_BITS) + 64'd35760000) / 64'd71520000);
    localparam logic [DCW-1:0] D_GCR_709 =
        DCW'(((64'd33480248 << FRAC_BITS) + 64'd35760000) / 64'd71520000);
    localparam logic [DCW-1:0] D_BCB_709 =
        DCW'(((64'd18556 << FRAC_BITS) + 64'd5000) / 64'd10000);

    localparam logic [ECW-1:0] KR_601 = ECW'(((64'd299 << FRAC_BITS) + 64'd500) / 64'd1000);
    localparam logic [ECW-1:0] KG_601 = ECW'(((64'd587 << FRAC_BITS) + 64'd500) / 64'd1000);
    localparam logic [ECW-1:0] KB_601 = ECW'(((64'd114 << FRAC_BITS) + 64'd500) / 64'd1000);
    localparam logic [ECW-1:0] KR_709 =
        ECW'(((64'd2126 << FRAC_BITS) + 64'd5000) / 64'd10000);
    localparam logic [ECW-1:0] KG_709 =
        ECW'(((64'd7152 << FRAC_BITS) + 64'd5000) / 64'd10000);
    localparam logic [ECW-1:0] KB_709 =
        ECW'(((64'd722 << FRAC_BITS) + 64'd5000) / 64'd10000);
    localparam logic [ECW-1:0] E_CB_601 =
        ECW'(((64'd1000 << FRAC_BITS) + 64'd886) / 64'd1772);
    localparam logic [ECW-1:0] E_CR_601 =
        ECW'(((64'd1000 << FRAC_BITS) + 64'd701) / 64'd1402);
    localparam logic [ECW-1:0] E_CB_709 =
        ECW'(((64'd10000 << FRAC_BITS) + 64'd9278) / 64'd18556);
    localparam logic [ECW-1:0] E_CR_709 =
        ECW'(((64'd10000 << FRAC_BITS) + 64'd7874) / 64'd15748);

    localparam logic signed [PW-1:0] HALF_2F = PW'(64'd255 << (2 * FRAC_BITS - 1));
    localparam logic [DIV_DW-1:0] DEN_65025 = 16'd65025;

    localparam logic [3:0] HSL_N [3] = '{4'd0, 4'd8, 4'd4};
    localparam logic [2:0] HSV_N [3] = '{3'd5, 3'd3, 3'd1};

    typedef struct packed {
        logic [7:0] c0;
        logic [7:0] c1;
        logic [7:0] c2;
    } t_pix;

    // clamp below zero, shift, saturate at 255
    function automatic logic [7:0] sat8(input logic signed [SATW-1:0] x,
                                       input logic [5:0] sh);
        logic signed [SATW-1:0] q;
        q = x >>> sh;
        if (x <= 0) begin
            return 8'd0;
        end else if (q > 255) begin
            return 8'd255;
        end
        return q[7:0];
    endfunction

endpackage

>>> rtl/core/csc_in_if.sv
`timescale 1ns / 1ps
// Pixel input channel: valid/ready handshake with three 8-bit channels.
// No dependencies.
interface csc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] chan_first;
    logic [7:0] chan_second;
    logic [7:0] chan_third;

    modport source (output valid, output chan_first, output chan_second,
                    output chan_third, input ready);
    modport sink   (input valid, input chan_first, input chan_second,
                    input chan_third, output ready);
endinterface

>>> rtl/core/csc_out_if.sv
`timescale 1ns / 1ps
// Pixel result channel: valid/ready handshake with three 8-bit channels.
// No dependencies.
interface csc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_first;
    logic [7:0] out_second;
    logic [7:0] out_third;

    modport source (output valid, output out_first, output out_second,
                    output out_third, input ready);
    modport sink   (input valid, input out_first, input out_second,
                    input out_third, output ready);
endinterface

>>> rtl/core/csc_div.sv
`timescale 1ns / 1ps
// Pipelined restoring divider, 8-bit quotient, two quotient bits per stage.
// Needs csc_pkg. Requires numerator < 256 * denominator.
module csc_div (
    input  logic                         i_clk,
    input  logic [csc_pkg::DIV_STG-1:0]  i_en,
    input  logic [csc_pkg::DIV_NW-1:0]   i_num,
    input  logic [csc_pkg::DIV_DW-1:0]   i_den,
    output logic [7:0]                   o_quo
);
    import csc_pkg::*;

    logic [DIV_NW-1:0] r_rem [DIV_STG];
    logic [DIV_DW-1:0] r_den [DIV_STG];
    logic [7:0]        r_quo [DIV_STG];

    for (genvar s = 0; s < DIV_STG; s++) begin : g_stg
        logic [DIV_NW-1:0] rem_in, rem_mid, n_rem, dv_hi, dv_lo;
        logic [DIV_DW-1:0] den_in;
        logic [7:0]        quo_in, n_quo;

        if (s == 0) begin : g_first
            assign rem_in = i_num;
            assign den_in = i_den;
            assign quo_in = 8'd0;
        end else begin : g_next
            assign rem_in = r_rem[s-1];
            assign den_in = r_den[s-1];
            assign quo_in = r_quo[s-1];
        end

        always_comb begin
            dv_hi   = DIV_NW'(den_in) << (7 - 2 * s);
            dv_lo   = DIV_NW'(den_in) << (6 - 2 * s);
            n_quo   = quo_in;
            rem_mid = rem_in;
            if (rem_in >= dv_hi) begin
                rem_mid          = rem_in - dv_hi;
                n_quo[7 - 2 * s] = 1'b1;
            end
            n_rem = rem_mid;
            if (rem_mid >= dv_lo) begin
                n_rem            = rem_mid - dv_lo;
                n_quo[6 - 2 * s] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en[s]) begin
                r_rem[s] <= n_rem;
                r_den[s] <= den_in;
                r_quo[s] <= n_quo;
            end
        end
    end

    assign o_quo = r_quo[DIV_STG-1];

endmodule

>>> rtl/core/csc_decode.sv
`timescale 1ns / 1ps
// Decode pipeline: source space to RGB over seven register stages.
// Needs csc_pkg and csc_div.
module csc_decode (
    input  logic                          i_clk,
    input  logic [csc_pkg::DEC_STG-1:0]   i_en,
    input  logic [2:0]                    i_src,
    input  csc_pkg::t_pix                 i_pix,
    output csc_pkg::t_pix                 o_rgb
);
    import csc_pkg::*;

    logic is_hsl, is_div, is_ycc, is_709;
    assign is_hsl = (i_src == SP_HSL);
    assign is_div = (i_src == SP_HSL) || (i_src == SP_HSV);
    assign is_ycc = (i_src == SP_Y601) || (i_src == SP_Y709);
    assign is_709 = (i_src == SP_Y709);

    // stage 0: input beat
    t_pix r_p0;
    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_p0 <= i_pix;
        end
    end

    // stage 1: hue ramps, saturation product, chroma products, simple spaces
    logic [15:0]            n_prod, r_prod;
    logic signed [9:0]      n_t [3];
    logic signed [9:0]      r_t [3];
    logic signed [PDW-1:0]  n_yp [4];
    logic signed [PDW-1:0]  r_yp [4];
    t_pix                   n_simp, r_simp;
    logic [7:0]             r_y, r_base;

    logic [DCW-1:0]         k_rcr, k_gcb, k_gcr, k_bcb;
    logic signed [9:0]      cbv, crv;
    logic [6:0]             m_l;
    logic [12:0]            kk;
    logic [11:0]            kv;
    logic signed [13:0]     t1, t2, tm, tv;
    logic signed [10:0]     sr, sg2, sb;

    always_comb begin
        k_rcr = is_709 ? D_RCR_709 : D_RCR_601;
        k_gcb = is_709 ? D_GCB_709 : D_GCB_601;
        k_gcr = is_709 ? D_GCR_709 : D_GCR_601;
        k_bcb = is_709 ? D_BCB_709 : D_BCB_601;
        cbv = $signed(10'({r_p0.c1, 1'b0})) - 10'sd255;
        crv = $signed(10'({r_p0.c2, 1'b0})) - 10'sd255;
        n_yp[0] = $signed({1'b0, k_rcr}) * crv;
        n_yp[1] = $signed({1'b0, k_gcb}) * cbv;
        n_yp[2] = $signed({1'b0, k_gcr}) * crv;
        n_yp[3] = $signed({1'b0, k_bcb}) * cbv;

        m_l    = r_p0.c2[7] ? 7'(8'd255 - r_p0.c2) : r_p0.c2[6:0];
        n_prod = 16'(r_p0.c1) * (is_hsl ? 16'(m_l) : 16'(r_p0.c2));

        for (int j = 0; j < 3; j++) begin
            kk = 13'(HSL_N[j]) * 13'd255 + 13'(r_p0.c0) * 13'd12;
            if (kk >= 13'd3060) begin
                kk = kk - 13'd3060;
            end
            t1 = $signed(14'(kk)) - 14'sd765;
            t2 = 14'sd2295 - $signed(14'(kk));
            tm = (t1 < t2) ? t1 : t2;
            if (tm > 14'sd255) begin
                tm = 14'sd255;
            end else if (tm < -14'sd255) begin
                tm = -14'sd255;
            end
            kv = 12'(HSV_N[j]) * 12'd255 + 12'(r_p0.c0) * 12'd6;
            if (kv >= 12'd1530) begin
                kv = kv - 12'd1530;
            end
            tv = $signed(14'(kv));
            if (14'sd1020 - tv < tv) begin
                tv = 14'sd1020 - tv;
            end
            if (tv > 14'sd255) begin
                tv = 14'sd255;
            end else if (tv < 14'sd0) begin
                tv = 14'sd0;
            end
            n_t[j] = is_hsl ? tm[9:0] : tv[9:0];
        end

        sr  = $signed(11'(r_p0.c0)) + $signed(11'(r_p0.c1)) - $signed(11'(r_p0.c2));
        sg2 = $signed(11'({r_p0.c0, 1'b0})) + $signed(11'({r_p0.c2, 1'b0})) - 11'sd255;
        sb  = $signed(11'(r_p0.c0)) - $signed(11'(r_p0.c1)) - $signed(11'(r_p0.c2))
              + 11'sd255;
        case (i_src)
            SP_YCOCG: begin
                n_simp.c0 = sat8(SATW'(sr), 6'd0);
                n_simp.c1 = sat8(SATW'(sg2), 6'd1);
                n_simp.c2 = sat8(SATW'(sb), 6'd0);
            end
            SP_CMY:  n_simp = ~r_p0;
            default: n_simp = r_p0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_prod <= n_prod;
            r_t    <= n_t;
            r_yp   <= n_yp;
            r_simp <= n_simp;
            r_y    <= r_p0.c0;
            r_base <= r_p0.c2;
        end
    end

    // stage 2: dividends over 65025, luma/chroma sums
    logic [DIV_NW-1:0]      n_num [3];
    logic [DIV_NW-1:0]      r_num [3];
    t_pix                   n_side, r_side;
    logic signed [27:0]     bm, dn;
    logic signed [26:0]     pp;
    logic signed [PDW-1:0]  y2, yr, yg, yb;

    always_comb begin
        bm = $signed(28'(r_base) * 28'd65025);
        for (int j = 0; j < 3; j++) begin
            pp = $signed({1'b0, r_prod}) * r_t[j];
            dn = bm - 28'(pp);
            n_num[j] = (dn <= 0) ? '0 : dn[DIV_NW-1:0];
        end
        y2 = $signed(PDW'({r_y, {(FRAC_BITS + 1){1'b0}}}));
        yr = y2 + r_yp[0];
        yg = y2 - r_yp[1] - r_yp[2];
        yb = y2 + r_yp[3];
        if (is_ycc) begin
            n_side.c0 = sat8(SATW'(yr), 6'(FRAC_BITS + 1));
            n_side.c1 = sat8(SATW'(yg), 6'(FRAC_BITS + 1));
            n_side.c2 = sat8(SATW'(yb), 6'(FRAC_BITS + 1));
        end else begin
            n_side = r_simp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_num  <= n_num;
            r_side <= n_side;
        end
    end

    // stages 3..6: divide by 65025, side result rides along
    logic [7:0] quo [3];
    for (genvar j = 0; j < 3; j++) begin : g_div
        csc_div u_div (
            .i_clk (i_clk),
            .i_en  (i_en[DEC_STG-1:3]),
            .i_num (r_num[j]),
            .i_den (DEN_65025),
            .o_quo (quo[j])
        );
    end

    t_pix r_sd [DIV_STG];
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < DIV_STG; k++) begin
            if (i_en[3 + k]) begin
                r_sd[k] <= (k == 0) ? r_side : r_sd[(k == 0) ? 0 : k - 1];
            end
        end
    end

    always_comb begin
        if (is_div) begin
            o_rgb = '{c0: quo[0], c1: quo[1], c2: quo[2]};
        end else begin
            o_rgb = r_sd[DIV_STG-1];
        end
    end

endmodule

>>> rtl/core/csc_encode.sv
`timescale 1ns / 1ps
// Encode pipeline: RGB to target space over seven register stages,
// the last one being the output register. Needs csc_pkg and csc_div.
module csc_encode (
    input  logic                          i_clk,
    input  logic [csc_pkg::ENC_STG-1:0]   i_en,
    input  logic [2:0]                    i_tgt,
    input  csc_pkg::t_pix                 i_rgb,
    output csc_pkg::t_pix                 o_res
);
    import csc_pkg::*;

    logic is_hsl, is_div, is_ycc, is_709;
    assign is_hsl = (i_tgt == SP_HSL);
    assign is_div = (i_tgt == SP_HSL) || (i_tgt == SP_HSV);
    assign is_ycc = (i_tgt == SP_Y601) || (i_tgt == SP_Y709);
    assign is_709 = (i_tgt == SP_Y709);

    // stage 0: extremes, hue numerator, luma products, simple spaces
    logic [7:0]          mx, mn, n_cr, r_cr, r_mx, r_r, r_b;
    logic [8:0]          sum, n_d, r_d;
    logic signed [11:0]  hn;
    logic [10:0]         n_hn, r_hn, six;
    logic [ECW+7:0]      n_kp [3];
    logic [ECW+7:0]      r_kp [3];
    t_pix                n_s1, r_s1;
    logic [9:0]          yo0;
    logic [8:0]          yo1;
    logic [10:0]         yo2;

    always_comb begin
        mx = (i_rgb.c0 > i_rgb.c1) ? i_rgb.c0 : i_rgb.c1;
        if (i_rgb.c2 > mx) begin
            mx = i_rgb.c2;
        end
        mn = (i_rgb.c0 < i_rgb.c1) ? i_rgb.c0 : i_rgb.c1;
        if (i_rgb.c2 < mn) begin
            mn = i_rgb.c2;
        end
        n_cr = mx - mn;
        sum  = 9'(mx) + 9'(mn);
        n_d  = (sum < 9'd255) ? sum : 9'd510 - sum;
        six  = 11'(n_cr) * 11'd6;
        if (mx == i_rgb.c0) begin
            hn = $signed(12'(i_rgb.c1)) - $signed(12'(i_rgb.c2));
        end else if (mx == i_rgb.c1) begin
            hn = $signed(12'({n_cr, 1'b0})) + $signed(12'(i_rgb.c2))
                 - $signed(12'(i_rgb.c0));
        end else begin
            hn = $signed(12'({n_cr, 2'b0})) + $signed(12'(i_rgb.c0))
                 - $signed(12'(i_rgb.c1));
        end
        if (hn < 0) begin
            hn = hn + $signed(12'(six));
        end
        n_hn = hn[10:0];

        n_kp[0] = (is_709 ? KR_709 : KR_601) * (ECW + 8)'(i_rgb.c0);
        n_kp[1] = (is_709 ? KG_709 : KG_601) * (ECW + 8)'(i_rgb.c1);
        n_kp[2] = (is_709 ? KB_709 : KB_601) * (ECW + 8)'(i_rgb.c2);

        yo0 = 10'(i_rgb.c0) + 10'({i_rgb.c1, 1'b0}) + 10'(i_rgb.c2);
        yo1 = 9'(i_rgb.c0) + 9'd255 - 9'(i_rgb.c2);
        yo2 = 11'({i_rgb.c1, 1'b0}) + 11'd510 - 11'(i_rgb.c0) - 11'(i_rgb.c2);
        case (i_tgt)
            SP_HSL:   n_s1 = '{c0: 8'd0, c1: 8'd0, c2: sum[8:1]};
            SP_HSV:   n_s1 = '{c0: 8'd0, c1: 8'd0, c2: mx};
            SP_YCOCG: n_s1 = '{c0: yo0[9:2], c1: yo1[8:1], c2: yo2[9:2]};
            SP_CMY:   n_s1 = ~i_rgb;
            default:  n_s1 = i_rgb;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_cr <= n_cr;
            r_mx <= mx;
            r_d  <= n_d;
            r_hn <= n_hn;
            r_kp <= n_kp;
            r_s1 <= n_s1;
            r_r  <= i_rgb.c0;
            r_b  <= i_rgb.c2;
        end
    end

    // stage 1: divider operands, luma sum, chroma differences
    logic [DIV_NW-1:0]      n_hnum, r_hnum, n_snum, r_snum;
    logic [DIV_DW-1:0]      n_hden, r_hden, n_sden, r_sden;
    logic [ECW+9:0]         n_yfx, r_yfx;
    logic signed [DBW-1:0]  n_db, r_db, n_dr, r_dr;
    t_pix                   r_s2;

    always_comb begin
        if (r_cr == 8'd0) begin
            n_hnum = '0;
            n_hden = DIV_DW'(1);
        end else begin
            n_hnum = DIV_NW'(r_hn) * DIV_NW'(255);
            n_hden = DIV_DW'(r_cr) * DIV_DW'(6);
        end
        n_snum = DIV_NW'(r_cr) * DIV_NW'(255);
        n_sden = is_hsl ? DIV_DW'(r_d) : DIV_DW'(r_mx);
        if (n_sden == '0) begin
            n_snum = '0;
            n_sden = DIV_DW'(1);
        end
        n_yfx = (ECW + 10)'(r_kp[0]) + (ECW + 10)'(r_kp[1]) + (ECW + 10)'(r_kp[2]);
        n_db  = $signed(DBW'({r_b, {FRAC_BITS{1'b0}}})) - $signed(DBW'(n_yfx));
        n_dr  = $signed(DBW'({r_r, {FRAC_BITS{1'b0}}})) - $signed(DBW'(n_yfx));
    end

    always_ff @(posedge i_clk) begin
        if (i_en[1]) begin
            r_hnum <= n_hnum;
            r_hden <= n_hden;
            r_snum <= n_snum;
            r_sden <= n_sden;
            r_yfx  <= n_yfx;
            r_db   <= n_db;
            r_dr   <= n_dr;
            r_s2   <= r_s1;
        end
    end

    // stages 2..5: hue and saturation division
    logic [7:0] hq, sq;
    csc_div u_hdiv (
        .i_clk (i_clk),
        .i_en  (i_en[5:2]),
        .i_num (r_hnum),
        .i_den (r_hden),
        .o_quo (hq)
    );
    csc_div u_sdiv (
        .i_clk (i_clk),
        .i_en  (i_en[5:2]),
        .i_num (r_snum),
        .i_den (r_sden),
        .o_quo (sq)
    );

    // stage 2: chroma scale
    logic signed [EPW-1:0] pcb, pcr;
    logic signed [PW-1:0]  r_pcb, r_pcr;
    logic [7:0]            r_y;
    t_pix                  r_s3;

    always_comb begin
        pcb = r_db * $signed({1'b0, (is_709 ? E_CB_709 : E_CB_601)});
        pcr = r_dr * $signed({1'b0, (is_709 ? E_CR_709 : E_CR_601)});
    end

    always_ff @(posedge i_clk) begin
        if (i_en[2]) begin
            r_pcb <= PW'(pcb) + HALF_2F;
            r_pcr <= PW'(pcr) + HALF_2F;
            r_y   <= sat8(SATW'($signed({1'b0, r_yfx})), 6'(FRAC_BITS));
            r_s3  <= r_s2;
        end
    end

    // stage 3: chroma saturate, then hold alongside the dividers
    t_pix r_s4, r_s5, r_s6, r_out;
    always_ff @(posedge i_clk) begin
        if (i_en[3]) begin
            if (is_ycc) begin
                r_s4 <= '{c0: r_y,
                          c1: sat8(SATW'(r_pcb), 6'(2 * FRAC_BITS)),
                          c2: sat8(SATW'(r_pcr), 6'(2 * FRAC_BITS))};
            end else begin
                r_s4 <= r_s3;
            end
        end
        if (i_en[4]) begin
            r_s5 <= r_s4;
        end
        if (i_en[5]) begin
            r_s6 <= r_s5;
        end
        if (i_en[6]) begin
            r_out <= is_div ? '{c0: hq, c1: sq, c2: r_s6.c2} : r_s6;
        end
    end

    assign o_res = r_out;

endmodule

>>> rtl/core/color_space_converter_unit.sv
`timescale 1ns / 1ps
// Color space converter top level: config registers, stage valid chain,
// decode and encode pipelines. Needs csc_pkg, csc_in_if, csc_out_if, csc_decode, csc_encode.
//
//   channel   dir  handshake     payload
//   i_pix     in   valid/ready   chan_first, chan_second, chan_third
//   o_pix     out  valid/ready   out_first, out_second, out_third
//   i_cfg_*   in   write enable  i_cfg_idx (0 source, 1 target), i_cfg_data
//
// One beat per clock in and out while the output is not stalled, through 14 register stages
// (7 decode, 7 encode, each with a 4-stage divider section at 2 quotient bits a stage).
// Each stage advances when it is empty or the next one advances, so bubbles
// close up and a stalled output holds without loss. Synchronous reset clears
// the valid bits and both space registers to RGB.
module color_space_converter_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    csc_in_if.sink     i_pix,
    csc_out_if.source  o_pix,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [2:0] i_cfg_data
);
    import csc_pkg::*;

    logic [2:0]      r_src, r_tgt;
    logic [NSTG-1:0] r_vld, en;
    t_pix            pix_in, rgb, res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src <= SP_RGB;
            r_tgt <= SP_RGB;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_SRC) begin
                r_src <= i_cfg_data;
            end else begin
                r_tgt <= i_cfg_data;
            end
        end
    end

    always_comb begin
        en[NSTG-1] = ~r_vld[NSTG-1] | o_pix.ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            en[k] = ~r_vld[k] | en[k + 1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[0]) begin
                r_vld[0] <= i_pix.valid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k - 1];
                end
            end
        end
    end

    assign i_pix.ready = en[0];
    assign pix_in = '{c0: i_pix.chan_first, c1: i_pix.chan_second, c2: i_pix.chan_third};

    csc_decode u_dec (
        .i_clk (i_clk),
        .i_en  (en[DEC_STG-1:0]),
        .i_src (r_src),
        .i_pix (pix_in),
        .o_rgb (rgb)
    );

    csc_encode u_enc (
        .i_clk (i_clk),
        .i_en  (en[NSTG-1:DEC_STG]),
        .i_tgt (r_tgt),
        .i_rgb (rgb),
        .o_res (res)
    );

    assign o_pix.valid      = r_vld[NSTG-1];
    assign o_pix.out_first  = res.c0;
    assign o_pix.out_second = res.c1;
    assign o_pix.out_third  = res.c2;

endmodule

>>> test/color_space_converter_unit_test.sv
`timescale 1ns / 1ps
// Self-checking bench for color_space_converter_unit: pixel beats through all
// source/target space pairs, checked against an in-bench predictor.
// Needs csc_pkg, csc_in_if, csc_out_if and the converter RTL.
module color_space_converter_unit_test;
    import csc_pkg::*;

    typedef struct packed {
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
    } pixel_t;

    localparam int F = FRAC_BITS;
    localparam longint LIMIT = 400000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic i_cfg_idx = CFG_SRC;
    logic [2:0] i_cfg_data = SP_RGB;

    csc_in_if  pix_in ();
    csc_out_if pix_out ();

    color_space_converter_unit dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_pix(pix_in.sink), .o_pix(pix_out.source),
        .i_cfg_we(i_cfg_we), .i_cfg_idx(i_cfg_idx), .i_cfg_data(i_cfg_data)
    );

    always #1 i_clk = ~i_clk;

    pixel_t pending_pixels[$];
    pixel_t expected_pixels[$];
    logic [2:0] src_space = SP_RGB;
    logic [2:0] dst_space = SP_RGB;
    bit calm = 1'b0;
    int errors = 0;
    int checked = 0;
    longint cycles = 0;

    function automatic longint fx(longint n, longint d);
        return ((n <<< F) + d / 2) / d;
    endfunction

    function automatic longint sat_shift(longint x, int sh);
        longint q;
        if (x <= 0) return 0;
        q = x >>> sh;
        return q > 255 ? 255 : q;
    endfunction

    function automatic longint clamp_div(longint num, longint den);
        longint q;
        if (num <= 0) return 0;
        q = num / den;
        return q > 255 ? 255 : q;
    endfunction

    function automatic longint hsl_k(longint h, longint s, longint l, longint n);
        longint kk, t, m;
        kk = (255 * n + 12 * h) % 3060;
        t = (kk - 765) < (2295 - kk) ? kk - 765 : 2295 - kk;
        m = l < 255 - l ? l : 255 - l;
        if (t > 255) t = 255;
        if (t < -255) t = -255;
        return clamp_div(l * 65025 - s * m * t, 65025);
    endfunction

    function automatic longint hsv_k(longint h, longint s, longint v, longint n);
        longint kk, t;
        kk = (255 * n + 6 * h) % 1530;
        t = kk < 1020 - kk ? kk : 1020 - kk;
        if (t > 255) t = 255;
        if (t < 0) t = 0;
        return clamp_div(v * 65025 - v * s * t, 65025);
    endfunction

    function automatic longint hue_of(longint r, longint g, longint b, longint mx, longint cr);
        longint num;
        if (cr == 0) return 0;
        if (mx == r) num = g - b;
        else if (mx == g) num = 2 * cr + (b - r);
        else num = 4 * cr + (r - g);
        if (num < 0) num += 6 * cr;
        return clamp_div(255 * num, 6 * cr);
    endfunction

    function automatic pixel_t convert_pixel(pixel_t p, logic [2:0] src, logic [2:0] dst);
        longint a, b, c, r, g, bl, y2, cb, cr, mx, mn, ch, sum, d, yfx, half;
        longint drcr, dgcb, dgcr, dbcb, kr, kg, kb, ecb, ecr;
        longint o0, o1, o2;
        bit is709;
        a = p.a; b = p.b; c = p.c;
        is709 = (src == SP_Y709);
        drcr = is709 ? fx(15748, 10000) : fx(1402, 1000);
        dgcb = is709 ? fx(13397432, 71520000) : fx(202008, 587000);
        dgcr = is709 ? fx(33480248, 71520000) : fx(419198, 587000);
        dbcb = is709 ? fx(18556, 10000) : fx(1772, 1000);
        case (src)
            SP_HSL: begin
                r = hsl_k(a, b, c, 0); g = hsl_k(a, b, c, 8); bl = hsl_k(a, b, c, 4);
            end
            SP_HSV: begin
                r = hsv_k(a, b, c, 5); g = hsv_k(a, b, c, 3); bl = hsv_k(a, b, c, 1);
            end
            SP_Y601, SP_Y709: begin
                y2 = a <<< (F + 1);
                cb = 2 * b - 255;
                cr = 2 * c - 255;
                r = sat_shift(y2 + drcr * cr, F + 1);
                g = sat_shift(y2 - dgcb * cb - dgcr * cr, F + 1);
                bl = sat_shift(y2 + dbcb * cb, F + 1);
            end
            SP_YCOCG: begin
                r = sat_shift(2 * (a + b - c), 1);
                g = sat_shift(2 * a + 2 * c - 255, 1);
                bl = sat_shift(2 * (a - b - c + 255), 1);
            end
            SP_CMY: begin
                r = 255 - a; g = 255 - b; bl = 255 - c;
            end
            default: begin
                r = a; g = b; bl = c;
            end
        endcase
        mx = r > g ? r : g;
        if (bl > mx) mx = bl;
        mn = r < g ? r : g;
        if (bl < mn) mn = bl;
        ch = mx - mn;
        is709 = (dst == SP_Y709);
        kr = is709 ? fx(2126, 10000) : fx(299, 1000);
        kg = is709 ? fx(7152, 10000) : fx(587, 1000);
        kb = is709 ? fx(722, 10000) : fx(114, 1000);
        ecb = is709 ? fx(10000, 18556) : fx(1000, 1772);
        ecr = is709 ? fx(10000, 15748) : fx(1000, 1402);
        case (dst)
            SP_HSL: begin
                sum = mx + mn;
                d = sum < 510 - sum ? sum : 510 - sum;
                o0 = hue_of(r, g, bl, mx, ch);
                o1 = (d <= 0) ? 0 : clamp_div(255 * ch, d);
                o2 = sum / 2;
            end
            SP_HSV: begin
                o0 = hue_of(r, g, bl, mx, ch);
                o1 = (mx == 0) ? 0 : clamp_div(255 * ch, mx);
                o2 = mx;
            end
            SP_Y601, SP_Y709: begin
                yfx = kr * r + kg * g + kb * bl;
                half = 255 * (longint'(1) <<< (2 * F - 1));
                o0 = sat_shift(yfx, F);
                o1 = sat_shift(((bl <<< F) - yfx) * ecb + half, 2 * F);
                o2 = sat_shift(((r <<< F) - yfx) * ecr + half, 2 * F);
            end
            SP_YCOCG: begin
                o0 = (r + 2 * g + bl) / 4;
                o1 = (r - bl + 255) / 2;
                o2 = (2 * g - r - bl + 510) / 4;
            end
            SP_CMY: begin
                o0 = 255 - r; o1 = 255 - g; o2 = 255 - bl;
            end
            default: begin
                o0 = r; o1 = g; o2 = bl;
            end
        endcase
        return '{a: o0[7:0], b: o1[7:0], c: o2[7:0]};
    endfunction

    // driver
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (!i_rst_n) begin
            pix_in.valid <= 1'b0;
        end else if (!pix_in.valid || pix_in.ready) begin
            if (pending_pixels.size() != 0 && (calm || $urandom_range(99) >= 6)) begin
                pix_in.valid <= 1'b1;
                {pix_in.chan_first, pix_in.chan_second, pix_in.chan_third}
                    <= pending_pixels[0];
                expected_pixels.push_back(convert_pixel(pending_pixels[0],
                                                        src_space, dst_space));
                pending_pixels.pop_front();
            end else begin
                pix_in.valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        pixel_t want;
        if (i_rst_n) begin
            if (pix_out.valid && pix_out.ready) begin
                if (expected_pixels.size() == 0) begin
                    $error("unexpected beat %h %h %h", pix_out.out_first,
                           pix_out.out_second, pix_out.out_third);
                    errors = errors + 1;
                end else begin
                    want = expected_pixels.pop_front();
                    checked <= checked + 1;
                    if (pix_out.out_first !== want.a) begin
                        $error("out_first expected %0d got %0d", want.a, pix_out.out_first);
                        errors = errors + 1;
                    end
                    if (pix_out.out_second !== want.b) begin
                        $error("out_second expected %0d got %0d", want.b, pix_out.out_second);
                        errors = errors + 1;
                    end
                    if (pix_out.out_third !== want.c) begin
                        $error("out_third expected %0d got %0d", want.c, pix_out.out_third);
                        errors = errors + 1;
                    end
                end
            end
            pix_out.ready <= calm || $urandom_range(99) >= 6;
        end else begin
            pix_out.ready <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (cycles > LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic write_space(logic idx, logic [2:0] code);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= code;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_SRC) src_space = code;
        else dst_space = code;
    endtask

    task automatic drain;
        while (pending_pixels.size() != 0 || expected_pixels.size() != 0)
            @(posedge i_clk);
        repeat (NSTG + 4) @(posedge i_clk);
    endtask

    function automatic pixel_t random_pixel();
        pixel_t p;
        p = 24'($urandom);
        case ($urandom_range(7))
            0: p.a = $urandom_range(1) ? 8'd0 : 8'd255;
            1: p.b = $urandom_range(1) ? 8'd0 : 8'd255;
            2: p.c = $urandom_range(1) ? 8'd0 : 8'd255;
            3: begin p.b = p.a; p.c = p.a; end
            default: ;
        endcase
        return p;
    endfunction

    initial begin
        pixel_t corners[$];
        int n;
        pix_in.valid = 1'b0;
        pix_in.chan_first = 8'd0;
        pix_in.chan_second = 8'd0;
        pix_in.chan_third = 8'd0;
        pix_out.ready = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        corners = '{24'h000000, 24'hffffff, 24'h808080, 24'hff0000, 24'h00ff00,
                    24'h0000ff, 24'hffff00, 24'h00ffff, 24'hff00ff, 24'h7f807f,
                    24'h01fe01, 24'h00ff80, 24'hff0080, 24'h55aaff};
        // directed: reset spaces first, then every extreme pixel in each pair whose source equals its target
        foreach (corners[i]) pending_pixels.push_back(corners[i]);
        drain();
        for (int s = SP_RGB; s <= 7; s++) begin
            for (int t = SP_RGB; t <= 7; t++) begin
                write_space(CFG_SRC, s[2:0]);
                write_space(CFG_TGT, t[2:0]);
                calm = (s == 3);
                n = (s == 7 || t == 7) ? 10 : 34;
                if (s == 0 && t == 0) foreach (corners[i]) pending_pixels.push_back(corners[i]);
                else if (s == t) foreach (corners[i]) pending_pixels.push_back(corners[i]);
                repeat (n) pending_pixels.push_back(random_pixel());
                drain();
            end
        end
        $display("covered %0d beats over all 64 source/target space codes, %0d cycles",
                 checked, cycles);
        if (errors == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule
